FILE: rtl/obsd_pkg.sv
// shared constants and register codes for the oriented box distance core
package obsd_pkg;

  // default geometry of the coordinate fields and the smallest box extent
  localparam int COORD_WIDTH_DEF = 20;
  localparam int MIN_EXTENT_DEF  = 51;

  // fixed field widths
  localparam int DIR_W   = 16;
  localparam int EXT_W   = 19;
  localparam int DIST_W  = 21;

  // half extent in Q15 is the whole extent shifted by this much
  localparam int HALF_SHIFT = 14;

  // Q15 to Q8 rounding of an excess or of the inside term
  localparam int RND_SHIFT = 7;

  // Q8 to whole units at the output
  localparam int OUT_FRAC = 8;

  // positive excess clamp in Q15, already beyond the output range
  localparam longint EXCESS_CAP = 64'd34359738368;

  // excess in Q8, sum of three squares and its root
  localparam int XS_W   = 29;
  localparam int SQ_W   = 2 * XS_W;
  localparam int ROOT_W = XS_W;

  // reset values of the registers
  localparam int AXIS_COS_RST = 16384;
  localparam int EXTENT_RST   = 51;

  // register indexes on the write port
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_AXIS_COS   = 3'd2,
    REG_AXIS_SIN   = 3'd3,
    REG_BOX_LENGTH = 3'd4,
    REG_BOX_DEPTH  = 3'd5,
    REG_BOTTOM_Z   = 3'd6,
    REG_TOP_Z      = 3'd7
  } reg_index_t;

endpackage

FILE: rtl/obsd_frame.sv
// box frame transform: centre offset, rotation, abs and per-axis excess over the half extents
module obsd_frame
  import obsd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int MIN_EXTENT  = MIN_EXTENT_DEF,
  localparam int EW = COORD_WIDTH + 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [DIR_W-1:0]       axis_cos,
  input  logic signed [DIR_W-1:0]       axis_sin,
  input  logic        [EXT_W-1:0]       box_length,
  input  logic        [EXT_W-1:0]       box_depth,
  input  logic signed [COORD_WIDTH-1:0] bottom_z,
  input  logic signed [COORD_WIDTH-1:0] top_z,
  output logic                          out_valid,
  output logic signed [EW-1:0]          e_long,
  output logic signed [EW-1:0]          e_front,
  output logic signed [EW-1:0]          e_up
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int ZW   = COORD_WIDTH + 2;
  localparam int PW   = DW + DIR_W;
  localparam int SUMW = PW + 1;

  logic signed [COORD_WIDTH:0]   height;
  logic        [EXT_W-1:0]       ext_long;
  logic        [EXT_W-1:0]       ext_front;
  logic        [COORD_WIDTH-1:0] ext_up;

  logic                          v1, v2, v3, v4;
  logic signed [DW-1:0]          dx, dy;
  logic signed [ZW-1:0]          dz1, dz2;
  logic signed [PW-1:0]          p_xc, p_ys, p_yc, p_xs;
  logic signed [SUMW-1:0]        s_long, s_front;
  logic        [ZW-1:0]          z_abs;
  logic        [SUMW-1:0]        a_long, a_front;

  // extents with the minimum floor, refreshed every cycle from the registers
  assign height = (COORD_WIDTH+1)'(top_z) - (COORD_WIDTH+1)'(bottom_z);

  always_ff @(posedge clk) begin
    ext_long  <= (box_length > EXT_W'(MIN_EXTENT)) ? box_length : EXT_W'(MIN_EXTENT);
    ext_front <= (box_depth > EXT_W'(MIN_EXTENT)) ? box_depth : EXT_W'(MIN_EXTENT);
    ext_up    <= (height > $signed((COORD_WIDTH+1)'(MIN_EXTENT))) ?
                 height[COORD_WIDTH-1:0] : COORD_WIDTH'(MIN_EXTENT);
  end

  // valid bits travel with the item
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // offset from the centre and doubled height relative to the mid height
  always_ff @(posedge clk) begin
    if (en) begin
      dx  <= DW'(point_x) - DW'(center_x);
      dy  <= DW'(point_y) - DW'(center_y);
      dz1 <= (ZW'(point_z) <<< 1) - ZW'(bottom_z) - ZW'(top_z);
    end
  end

  // rotation products
  always_ff @(posedge clk) begin
    if (en) begin
      p_xc <= dx * axis_cos;
      p_ys <= dy * axis_sin;
      p_yc <= dy * axis_cos;
      p_xs <= dx * axis_sin;
      dz2  <= dz1;
    end
  end

  // projected coordinates, half of q in Q15
  always_ff @(posedge clk) begin
    if (en) begin
      s_long  <= SUMW'(p_xc) + SUMW'(p_ys);
      s_front <= SUMW'(p_yc) - SUMW'(p_xs);
      z_abs   <= ZW'(dz2[ZW-1] ? -dz2 : dz2);
    end
  end

  assign a_long  = s_long[SUMW-1] ? SUMW'(-s_long) : SUMW'(s_long);
  assign a_front = s_front[SUMW-1] ? SUMW'(-s_front) : SUMW'(s_front);

  // excess of |q| over the half extent, Q15
  always_ff @(posedge clk) begin
    if (en) begin
      e_long  <= $signed({{(EW-SUMW-1){1'b0}}, a_long, 1'b0}) -
                 $signed({{(EW-EXT_W-HALF_SHIFT){1'b0}}, ext_long, {HALF_SHIFT{1'b0}}});
      e_front <= $signed({{(EW-SUMW-1){1'b0}}, a_front, 1'b0}) -
                 $signed({{(EW-EXT_W-HALF_SHIFT){1'b0}}, ext_front, {HALF_SHIFT{1'b0}}});
      e_up    <= (EW'($signed({1'b0, z_abs})) - EW'($signed({1'b0, ext_up})))
                 <<< HALF_SHIFT;
    end
  end

  assign out_valid = v4;

endmodule

FILE: rtl/obsd_excess.sv
// outside excess rounding and squaring, largest excess and inside term
module obsd_excess
  import obsd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int EW = COORD_WIDTH + 20,
  localparam int IW = EW - 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [EW-1:0] e_long,
  input  logic signed [EW-1:0] e_front,
  input  logic signed [EW-1:0] e_up,
  output logic                 out_valid,
  output logic [SQ_W-1:0]      sum_sq,
  output logic [IW-1:0]        inside_mag
);

  localparam logic signed [EW-1:0] CAP_E    = EW'(EXCESS_CAP);
  localparam logic        [EW:0]   RND_HALF = (EW+1)'(1 << (RND_SHIFT - 1));

  logic                 v1, v2, v3;
  logic [XS_W-1:0]      ox, oy, oz;
  logic signed [EW-1:0] e_max_a, e_max;
  logic signed [EW-1:0] emax;
  logic [EW-1:0]        neg_emax;
  logic [EW:0]          neg_rnd;
  logic [SQ_W-1:0]      sq_x, sq_y, sq_z;
  logic [IW-1:0]        mag2;

  // clamp a positive excess and round Q15 to Q8
  function automatic logic [XS_W-1:0] excess_q8(input logic signed [EW-1:0] e);
    logic [EW-1:0] v;
    logic [EW:0]   r;
    if (e <= 0) begin
      v = '0;
    end else if (e > CAP_E) begin
      v = CAP_E;
    end else begin
      v = e;
    end
    r = {1'b0, v} + RND_HALF;
    return r[RND_SHIFT +: XS_W];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // largest excess over the three axes
  assign e_max_a = (e_front > e_long) ? e_front : e_long;
  assign e_max   = (e_up > e_max_a) ? e_up : e_max_a;

  always_ff @(posedge clk) begin
    if (en) begin
      ox   <= excess_q8(e_long);
      oy   <= excess_q8(e_front);
      oz   <= excess_q8(e_up);
      emax <= e_max;
    end
  end

  // inside magnitude rounded half away from zero
  assign neg_emax = EW'(-emax);
  assign neg_rnd  = {1'b0, neg_emax} + RND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x <= SQ_W'(ox) * SQ_W'(ox);
      sq_y <= SQ_W'(oy) * SQ_W'(oy);
      sq_z <= SQ_W'(oz) * SQ_W'(oz);
      mag2 <= emax[EW-1] ? neg_rnd[EW:RND_SHIFT] : '0;
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      sum_sq     <= sq_x + sq_y + sq_z;
      inside_mag <= mag2;
    end
  end

  assign out_valid = v3;

endmodule

FILE: rtl/obsd_sqrt.sv
// pipelined integer square root, one result bit per stage, with a side value carried along
module obsd_sqrt
  import obsd_pkg::*;
#(
  parameter int SIDE_WIDTH = COORD_WIDTH_DEF + 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [SQ_W-1:0]       radicand,
  input  logic [SIDE_WIDTH-1:0] side_in,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     root,
  output logic [SIDE_WIDTH-1:0] side_out
);

  logic                  vld    [ROOT_W];
  logic [SQ_W-1:0]       rem_s  [ROOT_W];
  logic [ROOT_W-1:0]     root_s [ROOT_W];
  logic [SIDE_WIDTH-1:0] side_s [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;

    logic                  vld_in;
    logic [SQ_W-1:0]       rem_in;
    logic [ROOT_W-1:0]     root_in;
    logic [SIDE_WIDTH-1:0] side_in_k;
    logic [SQ_W-1:0]       trial;
    logic                  fits;

    if (k == 0) begin : g_first
      assign vld_in    = in_valid;
      assign rem_in    = radicand;
      assign root_in   = '0;
      assign side_in_k = side_in;
    end else begin : g_next
      assign vld_in    = vld[k-1];
      assign rem_in    = rem_s[k-1];
      assign root_in   = root_s[k-1];
      assign side_in_k = side_s[k-1];
    end

    // (root + 2^B)^2 - root^2 against the remainder
    assign trial = (SQ_W'(root_in) << (B + 1)) | (SQ_W'(1) << (2 * B));
    assign fits  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k]  <= fits ? (rem_in - trial) : rem_in;
        root_s[k] <= fits ? (root_in | (ROOT_W'(1) << B)) : root_in;
        side_s[k] <= side_in_k;
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign root      = root_s[ROOT_W-1];
  assign side_out  = side_s[ROOT_W-1];

endmodule

FILE: rtl/oriented_box_signed_distance_core.sv
// Signed distance from a 3-D point to an upright box turned about z, one point per cycle
// while the output buffer has room. A point accepted on the input channel passes the frame
// transform, the excess and squaring, the bit-per-stage square root and the rounding into
// the output buffer, in that order. A new point is accepted in every cycle while the
// two-entry output buffer has room. When the buffer is full the whole pipeline holds.
// Registers must be written through the plain write port only while no point is in flight;
// the core itself does not enforce this. The direction cos/sin is used as written, with no
// normalisation. Results are in the units of the point coordinates, negative inside the box,
// saturated to 21 bits.
module oriented_box_signed_distance_core
  import obsd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int MIN_EXTENT  = MIN_EXTENT_DEF,
  localparam int CFG_W = (COORD_WIDTH > EXT_W) ? COORD_WIDTH : EXT_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DIST_W-1:0]      signed_distance
);

  localparam int EW = COORD_WIDTH + 20;
  localparam int IW = EW - 6;
  localparam int TW = IW + 2;
  localparam int WW = TW - OUT_FRAC;

  localparam logic signed [TW-1:0] OUT_HALF = TW'(1 << (OUT_FRAC - 1));
  localparam logic signed [WW-1:0] D_MAX    = WW'((1 << (DIST_W - 1)) - 1);
  localparam logic signed [WW-1:0] D_MIN    = WW'(-(1 << (DIST_W - 1)));

  // registers
  logic signed [COORD_WIDTH-1:0] center_x, center_y, bottom_z, top_z;
  logic signed [DIR_W-1:0]       axis_cos, axis_sin;
  logic        [EXT_W-1:0]       box_length, box_depth;

  // pipeline links
  logic                 en;
  logic                 fr_valid, xs_valid, sq_valid;
  logic signed [EW-1:0] e_long, e_front, e_up;
  logic [SQ_W-1:0]      sum_sq;
  logic [IW-1:0]        inside_mag, inside_out;
  logic [ROOT_W-1:0]    root_out;

  // final rounding
  logic signed [TW-1:0]     total, total_rnd;
  logic signed [WW-1:0]     whole;
  logic signed [DIST_W-1:0] dist_sat;

  // output buffer
  logic [1:0]               count, count_next;
  logic signed [DIST_W-1:0] slot0, slot1;
  logic                     push, pop;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x   <= '0;
      center_y   <= '0;
      axis_cos   <= DIR_W'(AXIS_COS_RST);
      axis_sin   <= '0;
      box_length <= EXT_W'(EXTENT_RST);
      box_depth  <= EXT_W'(EXTENT_RST);
      bottom_z   <= '0;
      top_z      <= COORD_WIDTH'(EXTENT_RST);
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_CENTER_X:   center_x   <= cfg_data[COORD_WIDTH-1:0];
        REG_CENTER_Y:   center_y   <= cfg_data[COORD_WIDTH-1:0];
        REG_AXIS_COS:   axis_cos   <= cfg_data[DIR_W-1:0];
        REG_AXIS_SIN:   axis_sin   <= cfg_data[DIR_W-1:0];
        REG_BOX_LENGTH: box_length <= cfg_data[EXT_W-1:0];
        REG_BOX_DEPTH:  box_depth  <= cfg_data[EXT_W-1:0];
        REG_BOTTOM_Z:   bottom_z   <= cfg_data[COORD_WIDTH-1:0];
        REG_TOP_Z:      top_z      <= cfg_data[COORD_WIDTH-1:0];
      endcase
    end
  end

  // the pipeline moves while the output buffer has room
  assign en       = (count != 2'd2);
  assign in_ready = en;

  obsd_frame #(
    .COORD_WIDTH (COORD_WIDTH),
    .MIN_EXTENT  (MIN_EXTENT)
  ) u_frame (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .center_x   (center_x),
    .center_y   (center_y),
    .axis_cos   (axis_cos),
    .axis_sin   (axis_sin),
    .box_length (box_length),
    .box_depth  (box_depth),
    .bottom_z   (bottom_z),
    .top_z      (top_z),
    .out_valid  (fr_valid),
    .e_long     (e_long),
    .e_front    (e_front),
    .e_up       (e_up)
  );

  obsd_excess #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_excess (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (fr_valid),
    .e_long     (e_long),
    .e_front    (e_front),
    .e_up       (e_up),
    .out_valid  (xs_valid),
    .sum_sq     (sum_sq),
    .inside_mag (inside_mag)
  );

  obsd_sqrt #(
    .SIDE_WIDTH (IW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (xs_valid),
    .radicand  (sum_sq),
    .side_in   (inside_mag),
    .out_valid (sq_valid),
    .root      (root_out),
    .side_out  (inside_out)
  );

  // outside norm plus inside term, Q8 to whole units rounding half up, then saturate
  assign total     = $signed(TW'(root_out)) - $signed(TW'(inside_out));
  assign total_rnd = total + OUT_HALF;
  assign whole     = total_rnd[TW-1:OUT_FRAC];
  assign dist_sat  = (whole > D_MAX) ? DIST_W'(D_MAX) :
                     (whole < D_MIN) ? DIST_W'(D_MIN) : DIST_W'(whole);

  // two-entry output buffer
  assign push       = en && sq_valid;
  assign pop        = out_valid && out_ready;
  assign count_next = count + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
      end else begin
        slot0 <= dist_sat;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= dist_sat;
      end else begin
        slot1 <= dist_sat;
      end
    end
  end

  assign out_valid       = (count != 2'd0);
  assign signed_distance = slot0;

  // a held pipeline keeps its last item intact
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!en && sq_valid) |=> (sq_valid && $stable(root_out) && $stable(inside_out)))
    else $error("last pipeline item changed while stalled");

  // a result entering an empty buffer is shown next cycle
  a_push_empty: assert property (@(posedge clk) disable iff (rst)
    (push && count == 2'd0) |=> (out_valid && signed_distance == $past(dist_sat)))
    else $error("pushed result not presented");

  // taking from a full buffer moves the second item forward
  a_pop_full: assert property (@(posedge clk) disable iff (rst)
    (pop && count == 2'd2) |=> (out_valid && signed_distance == $past(slot1)))
    else $error("second buffered result lost");

  // buffer never overfills
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output buffer count out of range");

endmodule
